/* rtl/wpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam logic [1:0] OP_MASK = 2'd0;
	localparam logic [1:0] OP_SUBJ = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	// broadcast from the control logic to every cell
	typedef struct packed {
		logic       load;
		logic       step;
		logic       rearm;
		logic       fresh;
		logic [7:0] symbol;
	} wpm_ctrl_t;

	// handed from one cell to the next
	typedef struct packed {
		logic used;
		logic clo;
		logic adv;
	} wpm_link_t;

	// per-cell status back to the top
	typedef struct packed {
		logic act;
		logic hit;
	} wpm_cell_st_t;

	typedef struct packed {
		logic matched;
		logic mask_overflow;
	} wpm_res_t;

endpackage

/* rtl/wpm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_in_if
// Input channel of the wildcard pattern matcher: op and symbol per word.
// ----------------------------------------------------------------------------
interface wpm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] symbol;

	modport source(output valid, output op, output symbol, input ready);
	modport sink(input valid, input op, input symbol, output ready);
endinterface

/* rtl/wpm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_out_if
// Result channel of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
interface wpm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic mask_overflow;

	modport source(output valid, output matched, output mask_overflow, input ready);
	modport sink(input valid, input matched, input mask_overflow, output ready);
endinterface

/* rtl/wildcard_pattern_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Whole-string '*' / '?' wildcard match over a row of mask position cells.
// result: the end word's result is registered, via the skid stage if stalled
// throughput: one input word per cycle, every op, while the skid stage is
//   empty; star closure and advance ripple through all MASK_LEN cells
// reset: empty mask, position zero active, no overflow, result buffer empty
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
	parameter int MASK_LEN = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	wpm_in_if.sink   item,
	wpm_out_if.source result
);
	import wpm_pkg::*;

	logic                accept;
	logic                room;
	logic                push;
	wpm_ctrl_t           ctrl;
	wpm_res_t            res;
	logic                subject_seen_q;
	logic                overflow_q;
	logic                tail_act_q;
	logic                tail_cur;
	wpm_link_t           links [0:MASK_LEN];
	wpm_cell_st_t        stat  [0:MASK_LEN-1];
	logic [MASK_LEN-1:0] hit;
	logic [MASK_LEN-1:0] act;
	logic [MASK_LEN-1:0] used;
	logic [MASK_LEN:0]   act_pos;

	assign item.ready = room;
	assign accept     = item.valid & room;

	always_comb begin
		ctrl        = '0;
		ctrl.symbol = item.symbol;
		ctrl.fresh  = subject_seen_q;
		push        = 1'b0;
		if (accept) begin
			unique case (item.op)
				OP_MASK: begin
					ctrl.load  = 1'b1;
					ctrl.rearm = 1'b1;
				end
				OP_SUBJ: begin
					ctrl.step = 1'b1;
				end
				OP_END: begin
					ctrl.rearm = 1'b1;
					push       = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign links[0] = '{used: 1'b1, clo: 1'b0, adv: 1'b0};

	for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
		wpm_cell #(
			.HEAD(i == 0)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.prev  (links[i]),
			.next  (links[i+1]),
			.stat  (stat[i])
		);
		assign hit[i]  = stat[i].hit;
		assign act[i]  = stat[i].act;
		assign used[i] = links[i+1].used;
	end

	assign act_pos  = {tail_act_q, act};
	assign tail_cur = tail_act_q | links[MASK_LEN].clo;

	assign res.matched       = ((|hit) | (tail_cur & used[MASK_LEN-1])) & ~overflow_q;
	assign res.mask_overflow = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subject_seen_q <= 1'b0;
			overflow_q     <= 1'b0;
			tail_act_q     <= 1'b0;
		end else begin
			if (ctrl.load) begin
				subject_seen_q <= 1'b0;
				if (ctrl.fresh) begin
					overflow_q <= 1'b0;
				end else if (used[MASK_LEN-1]) begin
					overflow_q <= 1'b1;
				end
			end else if (ctrl.step || push) begin
				subject_seen_q <= 1'b1;
			end
			if (ctrl.rearm) begin
				tail_act_q <= 1'b0;
			end else if (ctrl.step) begin
				tail_act_q <= links[MASK_LEN].adv;
			end
		end
	end

	wpm_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.word  (res),
		.room  (room),
		.result(result)
	);

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.op == OP_END |=> result.valid)
		else $error("end word produced no result");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> used[MASK_LEN-1])
		else $error("overflow without a full mask store");

	a_used_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((used >> 1) & ~used) == '0)
		else $error("mask positions in use are not contiguous");

	a_active_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(act_pos[MASK_LEN:1] & ~used) == '0)
		else $error("active position beyond mask length");

endmodule

/* rtl/wpm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_cell
// One mask position: holds its mask byte, its in-use bit and its active bit,
// passes star closure and advance to the next position.
// ----------------------------------------------------------------------------
module wpm_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wpm_pkg::wpm_ctrl_t   ctrl,
	input  wpm_pkg::wpm_link_t   prev,
	output wpm_pkg::wpm_link_t   next,
	output wpm_pkg::wpm_cell_st_t stat
);
	import wpm_pkg::*;

	logic [7:0] sym_q;
	logic       used_q;
	logic       act_q;
	logic       cur;
	logic       is_star;
	logic       is_hit;
	logic       wr;

	assign is_star = (sym_q == STAR_BYTE);
	assign is_hit  = (sym_q == ANY_BYTE) || (sym_q == ctrl.symbol);
	assign cur     = act_q | prev.clo;

	assign next.used = used_q;
	assign next.clo  = cur & used_q & is_star;
	assign next.adv  = cur & used_q & ~is_star & is_hit;

	// position equals mask length
	assign stat.hit = cur & prev.used & ~used_q;
	assign stat.act = act_q;

	assign wr = ctrl.load & (ctrl.fresh ? HEAD : (prev.used & ~used_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= HEAD;
		end else begin
			if (ctrl.load) begin
				used_q <= ctrl.fresh ? HEAD : (used_q | wr);
			end
			if (ctrl.rearm) begin
				act_q <= HEAD;
			end else if (ctrl.step) begin
				act_q <= next.clo | prev.adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			sym_q <= ctrl.symbol;
		end
	end

endmodule

/* rtl/wpm_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_out_buf
// Result register with a skid stage behind it.
// ----------------------------------------------------------------------------
module wpm_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wpm_pkg::wpm_res_t word,
	output logic              room,
	wpm_out_if.source         result
);
	import wpm_pkg::*;

	logic     out_valid_q;
	logic     skid_valid_q;
	wpm_res_t out_q;
	wpm_res_t skid_q;
	logic     free;

	assign free = ~out_valid_q | result.ready;
	assign room = ~skid_valid_q;

	assign result.valid         = out_valid_q;
	assign result.matched       = out_q.matched;
	assign result.mask_overflow = out_q.mask_overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= skid_valid_q & push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= skid_valid_q ? skid_q : word;
		end
		if (push) begin
			skid_q <= word;
		end
	end

endmodule
